/* hdl/rdmc_pkg.sv */
// types and constants for the ramped dshot motor command unit
`timescale 1ns / 1ps
`default_nettype none

package rdmc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_PROTOCOL_MODE = 3'd0;
  localparam logic [2:0] CFG_RAMP_INTERVAL = 3'd1;
  localparam logic [2:0] CFG_SEND_INTERVAL = 3'd2;
  localparam logic [2:0] CFG_FULL_SCALE    = 3'd3;
  localparam logic [2:0] CFG_ONE_WIDTH     = 3'd4;
  localparam logic [2:0] CFG_ZERO_WIDTH    = 3'd5;

  // protocol mode codes
  localparam logic MODE_DSHOT    = 1'b0;
  localparam logic MODE_ONESHOT  = 1'b1;

  // command and compare value constants
  localparam logic [11:0] DSHOT_SPAN     = 12'd999;
  localparam logic [11:0] DSHOT_REVERSE  = 12'd1001;
  localparam logic [11:0] DSHOT_OFFSET   = 12'd48;
  localparam logic [11:0] DSHOT_CMD_MAX  = 12'd2047;
  localparam logic [11:0] ONESHOT_SPAN   = 12'd2500;
  localparam logic [15:0] ONESHOT_CENTER = 16'd7500;

  // reset values of the configuration registers
  localparam logic [31:0] RAMP_INTERVAL_RST = 32'd1000;
  localparam logic [31:0] SEND_INTERVAL_RST = 32'd1000;
  localparam logic [14:0] FULL_SCALE_RST    = 15'd1000;

  // divider geometry: 27 bit product, 13 quotient bits
  localparam int PROD_W = 27;
  localparam int QUOT_W = 13;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RAMP = 7'b0000010,
    ST_MULT = 7'b0000100,
    ST_PRE  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } rdmc_state_t;

endpackage

`default_nettype wire

/* hdl/ramped_dshot_motor_command_unit.sv */
// ramped speed setpoint to dshot frame or oneshot125 compare value encoder
// a new item is accepted only when the sequencer is idle; the quotient comes from the
//   13-step bit-serial divider, and a saturated quotient or a zero dshot speed skips
//   the divider
// a dshot item with a frame due gives 16 frame bits, which leave the frame shift register
//   one per cycle when taken, a oneshot125 item one word, and one with no frame due none
// reset: synchronous, clears the speed, both time stamps, the sequencer and the output
//   valid, and loads the configuration defaults
`timescale 1ns / 1ps
`default_nettype none

module ramped_dshot_motor_command_unit
  import rdmc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // input words
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        now_us,
  input  wire logic signed [15:0] target_speed,
  // result words
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             pulse_value,
  output logic [10:0]             command_word,
  output logic                    last_pulse
);

  // configuration registers
  logic        protocol_mode;
  logic [31:0] ramp_interval_us;
  logic [31:0] send_interval_us;
  logic [14:0] full_scale_speed;
  logic [15:0] one_bit_width;
  logic [15:0] zero_bit_width;

  // state
  rdmc_state_t        state;
  logic signed [15:0] present_speed;
  logic [31:0]        last_ramp_time;
  logic [31:0]        last_send_time;

  // working registers
  logic [31:0]        now_q;
  logic signed [15:0] target_q;
  logic               mode_q;
  logic               send_due;
  logic               neg_q;
  logic               mag_zero;
  logic [PROD_W-1:0]  product;
  logic [14:0]        rem;
  logic [QUOT_W-1:0]  dq;
  logic               sat;
  logic [3:0]         cnt;
  logic [15:0]        frame_sr;
  logic [10:0]        cmd_q;

  // combinational helpers
  logic               in_acc;
  logic               out_load;
  logic               out_set;
  logic [14:0]        divisor;
  logic [31:0]        ramp_diff;
  logic [31:0]        send_diff;
  logic [15:0]        mag;
  logic [11:0]        span;
  logic [15:0]        rem_shift;
  logic               rem_ge;
  logic [11:0]        scaled;
  logic [11:0]        cmd_sum;
  logic [10:0]        cmd_val;
  logic [11:0]        v_bits;
  logic [3:0]         csum;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = !out_valid || out_ready;

  // a new output word is loaded this cycle
  assign out_set = ((state == ST_FIN) && (mode_q == MODE_ONESHOT) && out_load) ||
                   ((state == ST_EMIT) && out_load);

  // zero full scale counts as one
  assign divisor = (full_scale_speed == 15'd0) ? 15'd1 : full_scale_speed;

  // wrapping time differences
  assign ramp_diff = now_q - last_ramp_time;
  assign send_diff = now_q - last_send_time;

  // magnitude and span of the present speed
  assign mag  = present_speed[15] ? 16'(-present_speed) : 16'(present_speed);
  assign span = (mode_q == MODE_ONESHOT) ? ONESHOT_SPAN : DSHOT_SPAN;

  // one restoring division step
  assign rem_shift = {rem, dq[QUOT_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});

  // clamp the quotient to the span
  always_comb begin
    if (sat || (dq > {1'b0, span})) begin
      scaled = span;
    end else begin
      scaled = dq[11:0];
    end
  end

  // dshot command and checksum
  always_comb begin
    cmd_sum = scaled + (neg_q ? DSHOT_REVERSE : 12'd0) + DSHOT_OFFSET;
    if (mag_zero) begin
      cmd_val = 11'd0;
    end else if (cmd_sum > DSHOT_CMD_MAX) begin
      cmd_val = DSHOT_CMD_MAX[10:0];
    end else begin
      cmd_val = cmd_sum[10:0];
    end
    v_bits = {cmd_val, 1'b0};
    csum   = v_bits[3:0] ^ v_bits[7:4] ^ v_bits[11:8];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode    <= MODE_DSHOT;
      ramp_interval_us <= RAMP_INTERVAL_RST;
      send_interval_us <= SEND_INTERVAL_RST;
      full_scale_speed <= FULL_SCALE_RST;
      one_bit_width    <= 16'd0;
      zero_bit_width   <= 16'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PROTOCOL_MODE: protocol_mode    <= cfg_data[0];
        CFG_RAMP_INTERVAL: ramp_interval_us <= cfg_data;
        CFG_SEND_INTERVAL: send_interval_us <= cfg_data;
        CFG_FULL_SCALE:    full_scale_speed <= cfg_data[14:0];
        CFG_ONE_WIDTH:     one_bit_width    <= cfg_data[15:0];
        CFG_ZERO_WIDTH:    zero_bit_width   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer, speed ramp and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      present_speed  <= 16'sd0;
      last_ramp_time <= 32'd0;
      last_send_time <= 32'd0;
      out_valid      <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_RAMP;
          end
        end
        ST_RAMP: begin
          if (ramp_diff > ramp_interval_us) begin
            last_ramp_time <= now_q;
            if (present_speed > target_q) begin
              present_speed <= present_speed - 16'sd1;
            end else if (present_speed < target_q) begin
              present_speed <= present_speed + 16'sd1;
            end
          end
          if ((mode_q == MODE_DSHOT) && (send_diff >= send_interval_us)) begin
            last_send_time <= now_q;
          end
          state <= ST_MULT;
        end
        ST_MULT: begin
          if ((mode_q == MODE_DSHOT) && !send_due) begin
            state <= ST_IDLE;
          end else if ((mode_q == MODE_DSHOT) && (mag == 16'd0)) begin
            state <= ST_FIN;
          end else begin
            state <= ST_PRE;
          end
        end
        ST_PRE: begin
          if ({1'b0, product[PROD_W-1:QUOT_W]} >= divisor) begin
            state <= ST_FIN;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == 4'(QUOT_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (mode_q == MODE_DSHOT) begin
            state <= ST_EMIT;
          end else if (out_load) begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_load && (cnt == 4'd15)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath: capture, multiply, bit-serial divide, frame shift
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          now_q    <= now_us;
          target_q <= target_speed;
          mode_q   <= protocol_mode;
        end
      end
      ST_RAMP: begin
        send_due <= (send_diff >= send_interval_us);
      end
      ST_MULT: begin
        neg_q    <= present_speed[15];
        mag_zero <= (mag == 16'd0);
        product  <= PROD_W'(mag * span);
        sat      <= 1'b0;
        dq       <= '0;
      end
      ST_PRE: begin
        sat <= ({1'b0, product[PROD_W-1:QUOT_W]} >= divisor);
        rem <= {1'b0, product[PROD_W-1:QUOT_W]};
        dq  <= product[QUOT_W-1:0];
        cnt <= 4'd0;
      end
      ST_DIV: begin
        rem <= rem_ge ? 15'(rem_shift - {1'b0, divisor}) : rem_shift[14:0];
        dq  <= {dq[QUOT_W-2:0], rem_ge};
        cnt <= cnt + 4'd1;
      end
      ST_FIN: begin
        cmd_q    <= cmd_val;
        frame_sr <= {v_bits, csum};
        cnt      <= 4'd0;
        if ((mode_q == MODE_ONESHOT) && out_load) begin
          pulse_value  <= neg_q ? (ONESHOT_CENTER + 16'(scaled))
                                : (ONESHOT_CENTER - 16'(scaled));
          command_word <= 11'd0;
          last_pulse   <= 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          pulse_value  <= frame_sr[15] ? one_bit_width : zero_bit_width;
          command_word <= cmd_q;
          last_pulse   <= (cnt == 4'd15);
          frame_sr     <= {frame_sr[14:0], 1'b0};
          cnt          <= cnt + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // an accepted word always starts the ramp step
  assert property (@(posedge clk) disable iff (rst) in_acc |=> (state == ST_RAMP))
    else $error("accepted word did not start the ramp step");

  // the ramped speed moves by at most one per cycle
  assert property (@(posedge clk) disable iff (rst)
    !rst |=> (present_speed == $past(present_speed)) ||
             (present_speed == $past(present_speed) + 16'sd1) ||
             (present_speed == $past(present_speed) - 16'sd1))
    else $error("present speed stepped by more than one");

  // divider remainder stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({1'b0, rem} < {1'b0, divisor}))
    else $error("division remainder out of range");

  // the sixteenth frame bit ends the item
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT) && out_load && (cnt == 4'd15)) |=> (state == ST_IDLE) && last_pulse)
    else $error("frame did not end after sixteen bits");

endmodule

`default_nettype wire

/* verif/ramped_dshot_motor_command_unit_tb.sv */
// self-checking testbench for the ramped dshot motor command unit
`timescale 1ns / 1ps

module ramped_dshot_motor_command_unit_tb
  import rdmc_pkg::*;
();

  localparam int CLK_HALF = 6;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  // one setpoint word waiting to be offered
  typedef struct {
    logic [31:0]        stamp;
    logic signed [15:0] speed;
    int unsigned        gap;
    bit                 drain;
  } setpoint_t;

  // one expected output word
  typedef struct {
    logic [15:0] pulse;
    logic [10:0] cmd;
    logic        last;
  } pulse_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        now_us = '0;
  logic signed [15:0] target_speed = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        pulse_value;
  logic [10:0]        command_word;
  logic               last_pulse;

  // shared testbench state
  setpoint_t   pending[$];
  pulse_word_t due_pulses[$];
  int          items_queued = 0;
  int          items_taken = 0;
  int          fail_count = 0;
  bit          calm = 1'b0;
  logic        hold_go = 1'b0;
  int          hold_left = 0;
  int          gap_cnt = 0;
  int          rx_wait = 0;

  // predictor copy of the configuration
  logic        mode_now = MODE_DSHOT;
  logic [31:0] ramp_gap = RAMP_INTERVAL_RST;
  logic [31:0] send_gap = SEND_INTERVAL_RST;
  logic [14:0] full_scale = FULL_SCALE_RST;
  logic [15:0] one_w = '0;
  logic [15:0] zero_w = '0;

  // predictor copy of the state
  int          speed_now = 0;
  logic [31:0] ramp_stamp = '0;
  logic [31:0] send_stamp = '0;

  ramped_dshot_motor_command_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .now_us       (now_us),
    .target_speed (target_speed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pulse_value  (pulse_value),
    .command_word (command_word),
    .last_pulse   (last_pulse)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // magnitude scaled to a span, divisor of zero read as one, saturated
  function automatic int unsigned scale_to(input int unsigned mag, input int unsigned span);
    int unsigned div;
    int unsigned s;
    div = (full_scale != 0) ? full_scale : 1;
    s = (mag * span) / div;
    return (s > span) ? span : s;
  endfunction

  // ramp the speed and work out the words this setpoint causes
  task automatic encode_setpoint(input logic [31:0] stamp, input logic signed [15:0] setpt);
    logic [31:0] since_ramp;
    logic [31:0] since_send;
    int unsigned mag;
    int unsigned sc;
    int unsigned cmd;
    logic [11:0] v;
    logic [3:0]  csum;
    logic [15:0] frame;
    bit          neg;
    pulse_word_t w;
    since_ramp = stamp - ramp_stamp;
    since_send = stamp - send_stamp;
    if (since_ramp > ramp_gap) begin
      ramp_stamp = stamp;
      if (speed_now > setpt) speed_now--;
      else if (speed_now < setpt) speed_now++;
    end
    neg = speed_now < 0;
    mag = neg ? -speed_now : speed_now;
    if (mode_now == MODE_ONESHOT) begin
      sc = scale_to(mag, ONESHOT_SPAN);
      w.pulse = neg ? 16'(ONESHOT_CENTER + sc) : 16'(ONESHOT_CENTER - sc);
      w.cmd = '0;
      w.last = 1'b1;
      due_pulses.push_back(w);
    end else if (since_send >= send_gap) begin
      send_stamp = stamp;
      cmd = 0;
      if (mag != 0) begin
        cmd = scale_to(mag, DSHOT_SPAN);
        if (neg) cmd += DSHOT_REVERSE;
        cmd += DSHOT_OFFSET;
        if (cmd > DSHOT_CMD_MAX) cmd = DSHOT_CMD_MAX;
      end
      // checksum over the nibbles of the shifted command
      v = {cmd[10:0], 1'b0};
      csum = v[3:0] ^ v[7:4] ^ v[11:8];
      frame = {v, csum};
      for (int k = 15; k >= 0; k--) begin
        w.pulse = frame[k] ? one_w : zero_w;
        w.cmd = cmd[10:0];
        w.last = (k == 0);
        due_pulses.push_back(w);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // register write, mirrored into the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_PROTOCOL_MODE: mode_now = val[0];
      CFG_RAMP_INTERVAL: ramp_gap = val;
      CFG_SEND_INTERVAL: send_gap = val;
      CFG_FULL_SCALE:    full_scale = val[14:0];
      CFG_ONE_WIDTH:     one_w = val[15:0];
      CFG_ZERO_WIDTH:    zero_w = val[15:0];
      default: ;
    endcase
  endtask

  task automatic queue_item(input logic [31:0] stamp, input logic [15:0] setpt,
                            input bit drain);
    setpoint_t it;
    it.stamp = stamp;
    it.speed = setpt;
    it.drain = drain;
    it.gap = calm ? 0 : $urandom_range(0, 15);
    pending.push_back(it);
    items_queued++;
  endtask

  // wait until every setpoint is taken and every word has come, then let the block finish
  task automatic wait_quiet();
    @(negedge clk);
    while (items_taken != items_queued || due_pulses.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: offers queued setpoints, predicts on acceptance
  always @(posedge clk) begin : drive_setpoints
    setpoint_t nxt;
    logic held;
    if (rst) begin
      in_valid <= 1'b0;
      gap_cnt = 0;
    end else begin
      held = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        encode_setpoint(now_us, target_speed);
        items_taken++;
      end
      if (!held) begin
        if (pending.size() != 0 && gap_cnt >= pending[0].gap &&
            (!pending[0].drain || due_pulses.size() == 0)) begin
          nxt = pending.pop_front();
          in_valid     <= 1'b1;
          now_us       <= nxt.stamp;
          target_speed <= nxt.speed;
          gap_cnt = 0;
        end else begin
          in_valid <= 1'b0;
          gap_cnt++;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver: takes words, compares against the oldest expectation
  always @(posedge clk) begin : take_words
    pulse_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_pulses.size() == 0) begin
          report_mismatch("word with nothing expected", pulse_value, 0);
        end else begin
          want = due_pulses.pop_front();
          if (pulse_value !== want.pulse)
            report_mismatch("pulse_value", pulse_value, want.pulse);
          if (command_word !== want.cmd)
            report_mismatch("command_word", command_word, want.cmd);
          if (last_pulse !== want.last)
            report_mismatch("last_pulse", last_pulse, want.last);
        end
        rx_wait = calm ? 0 : $urandom_range(0, 15);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // stimulus
  initial begin : run_phases
    logic [31:0] stamp;
    logic [31:0] r;
    int          goal;
    logic [15:0] setpt;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // defaults, widths at their extremes; first word too early to send
    write_reg(CFG_ONE_WIDTH, 32'd65535);
    write_reg(CFG_ZERO_WIDTH, 32'd0);
    queue_item(32'd0, 16'sd32767, 1'b0);
    queue_item(32'd1001, 16'sd32767, 1'b0);
    queue_item(32'hFFFF_FFFF, 16'h8000, 1'b0);
    // time wraps: exactly the interval since the last frame and ramp step
    queue_item(32'd999, 16'h8000, 1'b0);
    queue_item(32'd2000, 16'sd5, 1'b0);
    wait_quiet();

    // zero intervals, unit full scale: reverse command saturates
    write_reg(CFG_RAMP_INTERVAL, 32'd0);
    write_reg(CFG_SEND_INTERVAL, 32'd0);
    write_reg(CFG_FULL_SCALE, 32'd1);
    write_reg(CFG_ONE_WIDTH, 32'd0);
    write_reg(CFG_ZERO_WIDTH, 32'd65535);
    queue_item(32'd10, 16'h8000, 1'b0);
    queue_item(32'd11, 16'h8000, 1'b0);
    queue_item(32'd11, 16'sd32767, 1'b0);
    queue_item(32'd12, 16'sd32767, 1'b0);
    queue_item(32'd13, 16'sd32767, 1'b0);
    queue_item(32'd14, 16'sd32767, 1'b0);
    wait_quiet();

    // oneshot125 with zero full scale
    write_reg(CFG_PROTOCOL_MODE, MODE_ONESHOT);
    write_reg(CFG_FULL_SCALE, 32'd0);
    queue_item(32'd20, 16'sd32767, 1'b0);
    queue_item(32'd21, 16'h8000, 1'b0);
    queue_item(32'd22, 16'h8000, 1'b0);
    queue_item(32'd23, 16'h8000, 1'b0);
    wait_quiet();

    // maximal intervals: a frame only when the time difference is all ones
    write_reg(CFG_PROTOCOL_MODE, MODE_DSHOT);
    write_reg(CFG_FULL_SCALE, 32'd32767);
    write_reg(CFG_RAMP_INTERVAL, 32'hFFFF_FFFF);
    write_reg(CFG_SEND_INTERVAL, 32'hFFFF_FFFF);
    queue_item(32'd100, 16'sd0, 1'b0);
    queue_item(32'd13, 16'sd0, 1'b0);
    wait_quiet();

    // random phases over several settings
    stamp = $urandom;
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 2) || (ph == 3);
      write_reg(CFG_PROTOCOL_MODE,
                (ph == 1 || ph == 4 || ph == 7) ? MODE_ONESHOT : MODE_DSHOT);
      write_reg(CFG_RAMP_INTERVAL, (ph == 6) ? $urandom : $urandom_range(0, 60));
      write_reg(CFG_SEND_INTERVAL,
                (ph == 3) ? 32'd0 : (ph == 6) ? $urandom : $urandom_range(0, 300));
      write_reg(CFG_FULL_SCALE, (ph == 7) ? $urandom_range(1, 32767) : $urandom_range(1, 60));
      write_reg(CFG_ONE_WIDTH, $urandom_range(0, 65535));
      write_reg(CFG_ZERO_WIDTH, $urandom_range(0, 65535));
      goal = (ph % 2) ? -$urandom_range(1, 80) : $urandom_range(1, 80);
      for (int k = 0; k < 28; k++) begin
        if (ph == 6 || $urandom_range(0, 15) == 0) stamp = $urandom;
        else stamp = stamp + $urandom_range(0, 120);
        r = $urandom;
        setpt = ($urandom_range(0, 5) == 0) ? r[15:0] : goal[15:0];
        queue_item(stamp, setpt, (ph == 0 && k == 10) || (ph == 4 && k == 14));
      end
      // receiver stalls for a long stretch while the sender keeps offering
      if (ph == 3) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      wait_quiet();
    end

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // overall time limit
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* ramped_dshot_motor_command_unit.f */
hdl/rdmc_pkg.sv
hdl/ramped_dshot_motor_command_unit.sv
verif/ramped_dshot_motor_command_unit_tb.sv
